FILE: sv/vlru_pkg.sv
package vlru_pkg;

    // field widths fixed by the interface
    localparam int DIGEST_W  = 64;
    localparam int KIND_W    = 3;
    localparam int VALUE_W   = 64;
    localparam int VER_W     = 16;
    localparam int USES_W    = 32;
    localparam int STAMP_W   = 48;
    localparam int CAP_W     = 5;
    localparam int ACT_W     = 3;
    localparam int OUT_CNT_W = 5;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 3;

    // request codes
    localparam logic [ACT_W-1:0] ACT_LOOKUP    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DROP_VER  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DROP_KIND = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd4;

    // register index (address bit 2)
    localparam logic REG_VERSION  = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    localparam logic [VER_W-1:0] VER_RESET = 16'd0;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // slot contents apart from the key
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [VER_W-1:0]   version;
        logic [USES_W-1:0]  uses;
        logic [STAMP_W-1:0] stamp;
    } slot_meta_t;

    localparam int META_W = $bits(slot_meta_t);

    // sequencer states
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN_RD  = 8'b0000_0010,
        S_SCAN_CHK = 8'b0000_0100,
        S_EV_RD    = 8'b0000_1000,
        S_EV_CHK   = 8'b0001_0000,
        S_INS_WR   = 8'b0010_0000,
        S_LIMIT    = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } state_t;

endpackage

FILE: sv/vlru_ram.sv
module vlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/versioned_lru_memo_table_unit.sv
// channel   | direction | handshake                          | payload
// ----------+-----------+------------------------------------+---------------------------------
// request   | in        | start, busy (taken: start & !busy) | action, key_digest, entry_kind,
//           |           |                                    | payload_value, version_arg
// result    | out       | done (one cycle, no back-pressure) | hit, found_value, hit_count,
//           |           |                                    | entry_count, evicted
// config    | in/out    | apb psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
// lookup requests read the slots in order through the slot ram and stop at the first match;
// drop requests read every slot; clear and unknown codes go straight to the result.
// insert: one scan, a second scan for the oldest stamp when the table is full,
// one slot write, then one more scan per eviction over the capacity limit.
// the slot ram, read one slot at a time, sets the pace; busy stays high until done has been shown.
// reset clears valid bits, count and use clock at once; no clearing pass is needed.
// results cannot be stalled: done is high for exactly one cycle per request.
module versioned_lru_memo_table_unit
    import vlru_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ACT_W-1:0]     action,
    input  logic [DIGEST_W-1:0]  key_digest,
    input  logic [KIND_W-1:0]    entry_kind,
    input  logic [VALUE_W-1:0]   payload_value,
    input  logic [VER_W-1:0]     version_arg,
    output logic                 done,
    output logic                 hit,
    output logic [VALUE_W-1:0]   found_value,
    output logic [USES_W-1:0]    hit_count,
    output logic [OUT_CNT_W-1:0] entry_count,
    output logic                 evicted,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]     pwdata,
    output logic [APB_W-1:0]     prdata,
    output logic                 pready
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORD_W = KEY_BITS + META_W;

    // configuration registers
    logic [VER_W-1:0] cur_ver_reg;
    logic [CAP_W-1:0] cap_reg;
    logic             cfg_we;

    // control state
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [STAMP_W-1:0] clock_reg, clock_next;
    logic               free_found_reg, free_found_next;
    logic               vic_found_reg, vic_found_next;
    logic               ev_room_reg, ev_room_next;

    // request and scan payload
    logic [ACT_W-1:0]    act_reg, act_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [VALUE_W-1:0]  payload_reg, payload_next;
    logic [VER_W-1:0]    ver_arg_reg, ver_arg_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [IDX_W-1:0]    vic_idx_reg, vic_idx_next;
    logic [STAMP_W-1:0]  min_stamp_reg, min_stamp_next;

    // result registers
    logic               hit_reg, hit_next;
    logic [VALUE_W-1:0] found_reg, found_next;
    logic [USES_W-1:0]  hcount_reg, hcount_next;
    logic               evicted_reg, evicted_next;

    // slot ram
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;
    logic [KEY_BITS-1:0] rd_key;
    slot_meta_t          rd_meta;
    slot_meta_t          meta_hit;
    slot_meta_t          meta_new;

    // scan helpers
    logic               cur_valid;
    logic               key_match;
    logic               last_slot;
    logic [USES_W-1:0]  uses_inc;
    logic [STAMP_W-1:0] clock_inc;
    logic               take_cur;
    logic               vic_have;
    logic [IDX_W-1:0]   victim;
    logic [CMP_W-1:0]   cap_eff;
    logic               over_limit;

    vlru_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // apb configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_W'(cap_reg) : APB_W'(cur_ver_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_ver_reg <= VER_RESET;
            cap_reg     <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_CAPACITY)
            begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
            else
            begin
                cur_ver_reg <= pwdata[VER_W-1:0];
            end
        end
    end

    // slot word fields
    assign rd_key  = ram_rdata[WORD_W-1 -: KEY_BITS];
    assign rd_meta = slot_meta_t'(ram_rdata[META_W-1:0]);

    assign cur_valid = valid_reg[idx_reg];
    assign key_match = cur_valid && (rd_key == key_reg) && (rd_meta.kind == kind_reg);
    assign last_slot = (idx_reg == IDX_W'(ENTRIES - 1));
    assign uses_inc  = (rd_meta.uses == '1) ? rd_meta.uses : rd_meta.uses + USES_W'(1);
    assign clock_inc = clock_reg + STAMP_W'(1);

    // oldest-stamp search, lowest index wins a tie
    assign take_cur = cur_valid && (!vic_found_reg || (rd_meta.stamp < min_stamp_reg));
    assign vic_have = take_cur || vic_found_reg;
    assign victim   = take_cur ? idx_reg : vic_idx_reg;

    // capacity limit clipped to the table size
    assign cap_eff    = (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_reg);
    assign over_limit = CMP_W'(count_reg) > cap_eff;

    // slot words written back on a hit and on insert
    always_comb
    begin
        meta_hit       = rd_meta;
        meta_hit.uses  = uses_inc;
        meta_hit.stamp = clock_inc;

        meta_new.kind    = kind_reg;
        meta_new.value   = payload_reg;
        meta_new.version = cur_ver_reg;
        meta_new.uses    = '0;
        meta_new.stamp   = stamp_reg;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        clock_next      = clock_reg;
        free_found_next = free_found_reg;
        vic_found_next  = vic_found_reg;
        ev_room_next    = ev_room_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        kind_next       = kind_reg;
        payload_next    = payload_reg;
        ver_arg_next    = ver_arg_reg;
        stamp_next      = stamp_reg;
        free_idx_next   = free_idx_reg;
        slot_next       = slot_reg;
        vic_idx_next    = vic_idx_reg;
        min_stamp_next  = min_stamp_reg;
        hit_next        = hit_reg;
        found_next      = found_reg;
        hcount_next     = hcount_reg;
        evicted_next    = evicted_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {key_reg, meta_new};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next        = action;
                    key_next        = key_digest[KEY_BITS-1:0];
                    kind_next       = entry_kind;
                    payload_next    = payload_value;
                    ver_arg_next    = version_arg;
                    hit_next        = 1'b0;
                    found_next      = '0;
                    hcount_next     = '0;
                    evicted_next    = 1'b0;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    case (action)
                        ACT_LOOKUP, ACT_DROP_VER, ACT_DROP_KIND:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        ACT_INSERT:
                        begin
                            clock_next = clock_inc;
                            stamp_next = clock_inc;
                            state_next = S_SCAN_RD;
                        end
                        ACT_CLEAR:
                        begin
                            valid_next = '0;
                            count_next = '0;
                            clock_next = '0;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                case (act_reg)
                    ACT_LOOKUP:
                    begin
                        if (key_match)
                        begin
                            if (rd_meta.version == cur_ver_reg)
                            begin
                                // hit: bump count, restamp
                                ram_we      = 1'b1;
                                ram_wdata   = {rd_key, meta_hit};
                                clock_next  = clock_inc;
                                hit_next    = 1'b1;
                                found_next  = rd_meta.value;
                                hcount_next = uses_inc;
                            end
                            else
                            begin
                                // stale version is erased
                                valid_next[idx_reg] = 1'b0;
                                count_next          = count_reg - CNT_W'(1);
                            end
                            state_next = S_RESP;
                        end
                        else if (last_slot)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_SCAN_RD;
                        end
                    end

                    ACT_INSERT:
                    begin
                        if (key_match)
                        begin
                            slot_next  = idx_reg;
                            state_next = S_INS_WR;
                        end
                        else
                        begin
                            // remember the lowest free slot
                            if (!cur_valid && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = idx_reg;
                            end
                            if (last_slot)
                            begin
                                if (free_found_reg || !cur_valid)
                                begin
                                    slot_next  = free_found_reg ? free_idx_reg : idx_reg;
                                    state_next = S_INS_WR;
                                end
                                else
                                begin
                                    // table full: make room first
                                    ev_room_next   = 1'b1;
                                    vic_found_next = 1'b0;
                                    idx_next       = '0;
                                    state_next     = S_EV_RD;
                                end
                            end
                            else
                            begin
                                idx_next   = idx_reg + IDX_W'(1);
                                state_next = S_SCAN_RD;
                            end
                        end
                    end

                    ACT_DROP_VER, ACT_DROP_KIND:
                    begin
                        if (cur_valid &&
                            (((act_reg == ACT_DROP_VER) && (rd_meta.version != ver_arg_reg)) ||
                             ((act_reg == ACT_DROP_KIND) && (rd_meta.kind == kind_reg))))
                        begin
                            valid_next[idx_reg] = 1'b0;
                            count_next          = count_reg - CNT_W'(1);
                        end
                        if (last_slot)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_SCAN_RD;
                        end
                    end

                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_EV_RD:
            begin
                state_next = S_EV_CHK;
            end

            S_EV_CHK:
            begin
                if (take_cur)
                begin
                    vic_found_next = 1'b1;
                    vic_idx_next   = idx_reg;
                    min_stamp_next = rd_meta.stamp;
                end
                if (last_slot)
                begin
                    if (vic_have)
                    begin
                        valid_next[victim] = 1'b0;
                        count_next         = count_reg - CNT_W'(1);
                        evicted_next       = 1'b1;
                    end
                    if (ev_room_reg)
                    begin
                        ev_room_next = 1'b0;
                        slot_next    = victim;
                        state_next   = S_INS_WR;
                    end
                    else
                    begin
                        state_next = S_LIMIT;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_EV_RD;
                end
            end

            S_INS_WR:
            begin
                ram_we               = 1'b1;
                ram_waddr            = slot_reg;
                ram_wdata            = {key_reg, meta_new};
                valid_next[slot_reg] = 1'b1;
                if (!valid_reg[slot_reg])
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_LIMIT;
            end

            S_LIMIT:
            begin
                if (over_limit)
                begin
                    ev_room_next   = 1'b0;
                    vic_found_next = 1'b0;
                    idx_next       = '0;
                    state_next     = S_EV_RD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            clock_reg      <= '0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
            ev_room_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            evicted_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            clock_reg      <= clock_next;
            free_found_reg <= free_found_next;
            vic_found_reg  <= vic_found_next;
            ev_room_reg    <= ev_room_next;
            hit_reg        <= hit_next;
            evicted_reg    <= evicted_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        key_reg       <= key_next;
        kind_reg      <= kind_next;
        payload_reg   <= payload_next;
        ver_arg_reg   <= ver_arg_next;
        stamp_reg     <= stamp_next;
        free_idx_reg  <= free_idx_next;
        slot_reg      <= slot_next;
        vic_idx_reg   <= vic_idx_next;
        min_stamp_reg <= min_stamp_next;
        found_reg     <= found_next;
        hcount_reg    <= hcount_next;
    end

    // result ports
    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_RESP);
    assign hit         = hit_reg;
    assign found_value = found_reg;
    assign hit_count   = hcount_reg;
    assign entry_count = OUT_CNT_W'(count_reg);
    assign evicted     = evicted_reg;

`ifndef SYNTHESIS
    // entry count tracks the valid bits
    a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(valid_reg))
        else $error("entry count out of step with valid bits");

    // one result, then ready again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result");

    // only a lookup reports a hit
    a_hit_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (act_reg == ACT_LOOKUP))
        else $error("hit reported outside lookup");

    // an insert never leaves the table over its limit
    a_insert_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (act_reg == ACT_INSERT)) |-> !over_limit)
        else $error("table over capacity after insert");
`endif

endmodule

FILE: tb/tb.sv
import vlru_pkg::*;

localparam int TABLE_SLOTS = 16;

// one request as taken by the block
typedef struct {
    logic [ACT_W-1:0]    act;
    logic [DIGEST_W-1:0] digest;
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  word;
    logic [VER_W-1:0]    keep_ver;
} memo_request_t;

// one result as shown on the result ports
typedef struct {
    logic                 hit;
    logic [VALUE_W-1:0]   value;
    logic [USES_W-1:0]    uses;
    logic [OUT_CNT_W-1:0] live;
    logic                 evicted;
} memo_result_t;

// shadow copy of the memo table and the results it still owes
class memo_table_shadow;
    bit                 slot_live   [TABLE_SLOTS];
    bit [DIGEST_W-1:0]  slot_digest [TABLE_SLOTS];
    bit [KIND_W-1:0]    slot_kind   [TABLE_SLOTS];
    bit [VALUE_W-1:0]   slot_word   [TABLE_SLOTS];
    bit [VER_W-1:0]     slot_ver    [TABLE_SLOTS];
    bit [USES_W-1:0]    slot_uses   [TABLE_SLOTS];
    bit [STAMP_W-1:0]   slot_stamp  [TABLE_SLOTS];
    bit [STAMP_W-1:0]   stamp_clock;
    bit [VER_W-1:0]     cur_version;
    bit [CAP_W-1:0]     cap_limit;
    memo_result_t       due_results[$];
    int                 errors;

    function new();
        foreach (slot_live[i])
            slot_live[i] = 0;
        stamp_clock = '0;
        cur_version = VER_RESET;
        cap_limit   = CAP_RESET;
        errors      = 0;
    endfunction

    // register write seen on the config port
    function void note_config(logic [PADDR_W-1:0] addr, logic [APB_W-1:0] data);
        if (addr[2] == REG_VERSION)
            cur_version = data[VER_W-1:0];
        else
            cap_limit = data[CAP_W-1:0];
    endfunction

    function int find_entry(bit [DIGEST_W-1:0] key, bit [KIND_W-1:0] kind);
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot_live[i] && slot_digest[i] == key && slot_kind[i] == kind)
                return i;
        return -1;
    endfunction

    function int free_entry();
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (!slot_live[i])
                return i;
        return -1;
    endfunction

    function int live_total();
        int n;
        n = 0;
        foreach (slot_live[i])
            n += slot_live[i];
        return n;
    endfunction

    // smallest stamp goes, lowest index on a tie
    function void drop_oldest();
        int victim;
        victim = -1;
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot_live[i] && (victim < 0 || slot_stamp[i] < slot_stamp[victim]))
                victim = i;
        if (victim >= 0)
            slot_live[victim] = 0;
    endfunction

    function bit [STAMP_W-1:0] tick();
        stamp_clock = stamp_clock + 1'b1;
        return stamp_clock;
    endfunction

    // apply one accepted request and queue the result it owes
    function void note_request(memo_request_t r);
        memo_result_t res;
        int s;
        int lim;
        bit [STAMP_W-1:0] stamp;
        res = '{hit: 0, value: '0, uses: '0, live: '0, evicted: 0};
        case (r.act)
            ACT_LOOKUP:
            begin
                s = find_entry(r.digest, r.kind);
                if (s >= 0) begin
                    if (slot_ver[s] == cur_version) begin
                        if (slot_uses[s] != '1)
                            slot_uses[s]++;
                        slot_stamp[s] = tick();
                        res.hit   = 1;
                        res.value = slot_word[s];
                        res.uses  = slot_uses[s];
                    end
                    else begin
                        // stale entry is erased
                        slot_live[s] = 0;
                    end
                end
            end
            ACT_INSERT:
            begin
                stamp = tick();
                s = find_entry(r.digest, r.kind);
                if (s < 0)
                    s = free_entry();
                if (s < 0) begin
                    // full table: make room first
                    drop_oldest();
                    res.evicted = 1;
                    s = free_entry();
                end
                slot_live[s]   = 1;
                slot_digest[s] = r.digest;
                slot_kind[s]   = r.kind;
                slot_word[s]   = r.word;
                slot_ver[s]    = cur_version;
                slot_uses[s]   = '0;
                slot_stamp[s]  = stamp;
                lim = (cap_limit > TABLE_SLOTS) ? TABLE_SLOTS : cap_limit;
                while (live_total() > lim) begin
                    drop_oldest();
                    res.evicted = 1;
                end
            end
            ACT_DROP_VER:
            begin
                foreach (slot_live[i])
                    if (slot_ver[i] != r.keep_ver)
                        slot_live[i] = 0;
            end
            ACT_DROP_KIND:
            begin
                foreach (slot_live[i])
                    if (slot_kind[i] == r.kind)
                        slot_live[i] = 0;
            end
            ACT_CLEAR:
            begin
                foreach (slot_live[i])
                    slot_live[i] = 0;
                stamp_clock = '0;
            end
            default: ;
        endcase
        res.live = live_total();
        due_results.insert(due_results.size(), res);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // compare a shown result with the oldest one owed
    function void check_result(memo_result_t got);
        memo_result_t want;
        if (due_results.size() == 0) begin
            errors++;
            $display("%0t: result with none outstanding, expected none, actual hit=%h cnt=%h",
                     $time, got.hit, got.live);
            return;
        end
        want = due_results.pop_front();
        compare_field("hit", want.hit, got.hit);
        compare_field("found_value", want.value, got.value);
        compare_field("hit_count", want.uses, got.uses);
        compare_field("entry_count", want.live, got.live);
        compare_field("evicted", want.evicted, got.evicted);
    endfunction
endclass

module tb;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [ACT_W-1:0]     action;
    logic [DIGEST_W-1:0]  key_digest;
    logic [KIND_W-1:0]    entry_kind;
    logic [VALUE_W-1:0]   payload_value;
    logic [VER_W-1:0]     version_arg;
    logic                 done;
    logic                 hit;
    logic [VALUE_W-1:0]   found_value;
    logic [USES_W-1:0]    hit_count;
    logic [OUT_CNT_W-1:0] entry_count;
    logic                 evicted;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [APB_W-1:0]     pwdata;
    logic [APB_W-1:0]     prdata;
    logic                 pready;

    memo_table_shadow     shadow;
    logic [DIGEST_W-1:0]  key_pool [12];
    logic [VER_W-1:0]     ver_pool [4];
    bit                   no_idle;

    versioned_lru_memo_table_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .key_digest    (key_digest),
        .entry_kind    (entry_kind),
        .payload_value (payload_value),
        .version_arg   (version_arg),
        .done          (done),
        .hit           (hit),
        .found_value   (found_value),
        .hit_count     (hit_count),
        .entry_count   (entry_count),
        .evicted       (evicted),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog
    initial
    begin
        #100_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // sample requests, results and register writes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                shadow.check_result('{hit: hit, value: found_value, uses: hit_count,
                                      live: entry_count, evicted: evicted});
            if (start && !busy)
                shadow.note_request('{act: action, digest: key_digest, kind: entry_kind,
                                      word: payload_value, keep_ver: version_arg});
            if (psel && penable && pwrite && pready)
                shadow.note_config(paddr, pwdata);
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DIGEST_W-1:0] pick_digest();
        if ($urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, 11)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        if ($urandom_range(0, 3) < 3)
            return KIND_W'($urandom_range(0, 1));
        return KIND_W'($urandom_range(0, 7));
    endfunction

    task automatic issue(input logic [ACT_W-1:0] act, input logic [DIGEST_W-1:0] key,
                         input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] word,
                         input logic [VER_W-1:0] ver);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action        = act;
        key_digest    = key;
        entry_kind    = kind;
        payload_value = word;
        version_arg   = ver;
        start         = 1'b1;
        do @(posedge clk); while (busy);
    endtask

    // drop start and wait for the table to go quiet
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (shadow.due_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [APB_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic random_item();
        int r;
        logic [VER_W-1:0] ver;
        r = $urandom_range(0, 99);
        ver = ($urandom_range(0, 9) < 6) ? shadow.cur_version
                                         : (($urandom_range(0, 1) == 1) ? VER_W'($urandom)
                                                                        : ver_pool[$urandom_range(0, 3)]);
        if (r < 45)
            issue(ACT_LOOKUP, pick_digest(), pick_kind(), {$urandom, $urandom}, ver);
        else if (r < 80)
            issue(ACT_INSERT, pick_digest(), pick_kind(), {$urandom, $urandom}, ver);
        else if (r < 85)
            issue(ACT_DROP_VER, pick_digest(), pick_kind(), {$urandom, $urandom}, ver);
        else if (r < 90)
            issue(ACT_DROP_KIND, pick_digest(), pick_kind(), {$urandom, $urandom}, ver);
        else if (r < 93)
            issue(ACT_CLEAR, pick_digest(), pick_kind(), {$urandom, $urandom}, ver);
        else if (r < 96)
            issue(ACT_W'($urandom_range(5, 7)), pick_digest(), pick_kind(),
                  {$urandom, $urandom}, ver);
        else
            issue(ACT_LOOKUP, {$urandom, $urandom}, KIND_W'($urandom_range(0, 7)),
                  {$urandom, $urandom}, ver);
    endtask

    initial
    begin
        logic [DIGEST_W-1:0] ones;
        logic [DIGEST_W-1:0] k_a;
        int cap_pick;
        shadow = new();
        ones = '1;
        k_a  = 64'h0123_4567_89ab_cdef;
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = ones;
        ver_pool[0] = '0;
        ver_pool[1] = '1;
        ver_pool[2] = VER_W'($urandom);
        ver_pool[3] = VER_W'($urandom);
        no_idle       = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        action        = '0;
        key_digest    = '0;
        entry_kind    = '0;
        payload_value = '0;
        version_arg   = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: hits, misses, replace, kind as part of the key, unknown codes, drops by kind and version
        write_reg(REG_VERSION, 32'h0000_ffff);
        write_reg(REG_CAPACITY, 32'd16);
        issue(ACT_LOOKUP, '0, 3'd0, '0, '0);
        issue(ACT_INSERT, '0, 3'd0, '0, '0);
        issue(ACT_INSERT, ones, 3'd7, ones, '1);
        issue(ACT_LOOKUP, ones, 3'd7, '0, '0);
        issue(ACT_LOOKUP, ones, 3'd7, '0, '0);
        issue(ACT_LOOKUP, ones, 3'd6, '0, '0);
        issue(ACT_INSERT, '0, 3'd0, 64'ha5a5_5a5a_f0f0_0f0f, '0);
        issue(ACT_LOOKUP, '0, 3'd0, '0, '0);
        issue(ACT_W'(5), ones, 3'd5, ones, '1);
        issue(ACT_W'(7), '0, 3'd0, '0, '0);
        issue(ACT_INSERT, k_a, 3'd3, 64'h1111_2222_3333_4444, '0);
        issue(ACT_DROP_KIND, '0, 3'd7, '0, '0);
        issue(ACT_DROP_VER, '0, 3'd0, '0, 16'hffff);

        // directed: version change makes old entries stale
        settle();
        write_reg(REG_VERSION, 32'h0000_0000);
        issue(ACT_LOOKUP, '0, 3'd0, '0, '0);
        issue(ACT_INSERT, k_a, 3'd3, 64'h5555_6666_7777_8888, '0);
        issue(ACT_DROP_VER, '0, 3'd0, '0, 16'hffff);

        // directed: small capacity forces eviction
        settle();
        write_reg(REG_CAPACITY, 32'd2);
        issue(ACT_INSERT, 64'd1, 3'd1, 64'd10, '0);
        issue(ACT_INSERT, 64'd2, 3'd1, 64'd20, '0);
        issue(ACT_INSERT, 64'd3, 3'd1, 64'd30, '0);
        issue(ACT_LOOKUP, 64'd1, 3'd1, '0, '0);

        // directed: zero capacity drops even the new entry, then clear
        settle();
        write_reg(REG_CAPACITY, 32'd0);
        issue(ACT_INSERT, 64'd4, 3'd2, 64'd40, '0);
        issue(ACT_CLEAR, '0, 3'd0, '0, '0);

        // random phases, each under its own register setting
        for (int p = 0; p < 20; p++) begin
            settle();
            cap_pick = $urandom_range(0, 9);
            if (cap_pick < 4)
                write_reg(REG_CAPACITY, 32'd16);
            else if (cap_pick == 4)
                write_reg(REG_CAPACITY, ($urandom_range(0, 1) == 1) ? 32'd31
                                                                  : 32'($urandom_range(17, 31)));
            else if (cap_pick == 5)
                write_reg(REG_CAPACITY, 32'd0);
            else if (cap_pick == 6)
                write_reg(REG_CAPACITY, 32'd1);
            else
                write_reg(REG_CAPACITY, 32'($urandom_range(2, 15)));
            write_reg(REG_VERSION, {16'($urandom), ver_pool[$urandom_range(0, 3)]});
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (100) random_item();
        end

        // drain, then watch for stray results
        settle();
        repeat (100) @(posedge clk);
        if (shadow.errors == 0 && shadow.due_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
